>>> hdl/xypip_pkg.sv
// ----------------------------------------------------------------------------
// xypip_pkg
// Shared types and constants of the XY point interpolating player.
// ----------------------------------------------------------------------------
package xypip_pkg;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam int COORD_W     = 10;
  localparam int CFG_W       = 11;
  localparam int SAMPLE_W    = 16;
  // v*65535/1024 is (v<<16 - v) >> 10
  localparam int SCALE_SHIFT = 10;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MID = 16'd32767;

  typedef struct packed {
    logic               kind;
    logic [9:0]         point_index;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } sample_t;

endpackage

>>> hdl/xy_point_interpolating_player.sv
// ----------------------------------------------------------------------------
// xy_point_interpolating_player
// Point table with linear interpolation and scaling to a stereo sample pair.
// ----------------------------------------------------------------------------
// Usage: drive cmd and pulse start while busy is low. A load command
// (kind 0) writes one point into the table at that edge and leaves busy
// low, so loads can be issued back to back. A tick command (kind 1) raises
// busy; one shared signed multiplier, registered, forms
// (b-a)*k and then the reciprocal product num*R for x and y in turn.
// The result pair appears on result with result_valid high for exactly
// one cycle, the first cycle that busy is low again. A tick can be
// accepted in that same cycle. A new tick is not taken while one is
// in progress, as each tick needs two table reads on the single read port,
// four passes through the multiplier and a final scaling step. The
// receiver cannot stall; each beat is taken in the cycle it is shown.
// The user must write num_points through num_points_we/num_points_wdata
// only while idle; the block does not enforce it. Reset (rst,
// synchronous) sets num_points to 1 and clears the point pointers and
// phase; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module xy_point_interpolating_player #(
  parameter int MAX_POINTS        = 1024,
  parameter int STEPS_PER_SEGMENT = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  xypip_pkg::cmd_t                cmd,
  output logic                           result_valid,
  output xypip_pkg::sample_t             result,
  input  logic                           num_points_we,
  input  logic [xypip_pkg::CFG_W-1:0]    num_points_wdata
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int LS  = $clog2(STEPS_PER_SEGMENT);
  localparam int PW  = (STEPS_PER_SEGMENT > 1) ? LS : 1;
  localparam int KW  = $clog2(STEPS_PER_SEGMENT + 1);
  localparam int NW  = xypip_pkg::COORD_W + LS;
  localparam int SH  = NW + LS;
  localparam int RECIP = ((2 ** SH) + STEPS_PER_SEGMENT - 1) / STEPS_PER_SEGMENT;
  localparam int RW  = SH + 1;
  localparam int PRW = NW + RW + 2;
  localparam int CWD = xypip_pkg::COORD_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RDC  = 7'b0000010,
    ST_DX   = 7'b0000100,
    ST_DY   = 7'b0001000,
    ST_QX   = 7'b0010000,
    ST_QY   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [xypip_pkg::CFG_W-1:0] num_points;
  logic [CW-1:0]               cur;
  logic [AW-1:0]               prev;
  logic [PW-1:0]               phase;

  logic [2*CWD-1:0]            mem [MAX_POINTS];
  logic [2*CWD-1:0]            rdata;
  logic [AW-1:0]               rd_addr;
  logic                        rd_en;

  logic [CWD-1:0]              ax, ay, qx;
  logic [NW-1:0]               num;
  logic signed [NW:0]          op_a;
  logic signed [RW:0]          op_b;
  logic signed [PRW-1:0]       prod;
  logic signed [PRW-1:0]       base;
  logic signed [PRW-1:0]       sum;
  logic [NW-1:0]               a_scaled;
  logic [KW-1:0]               k;

  logic [31:0]                 n32;
  logic [CW-1:0]               cur_wrapped;
  logic                        accept, tick_accept, load_ok;
  logic [CWD-1:0]              qy;
  logic [CWD+16-1:0]           sx_full, sy_full;
  logic [xypip_pkg::SAMPLE_W-1:0] sx, sy;

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign tick_accept = accept && (cmd.kind == xypip_pkg::KIND_TICK);
  assign load_ok     = 32'(cmd.point_index) < 32'(MAX_POINTS);

  // Effective point count: zero acts as one, clamp at table depth
  always_comb begin
    if (num_points == '0) begin
      n32 = 32'd1;
    end else if (32'(num_points) > 32'(MAX_POINTS)) begin
      n32 = 32'(MAX_POINTS);
    end else begin
      n32 = 32'(num_points);
    end
    cur_wrapped = (32'(cur) >= n32) ? '0 : cur;
  end

  // Point table: x in the upper half, y in the lower half
  always_ff @(posedge clk) begin
    if (accept && (cmd.kind == xypip_pkg::KIND_LOAD) && load_ok) begin
      mem[AW'(cmd.point_index)] <= {cmd.x_coord, cmd.y_coord};
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign rd_en   = tick_accept || (state == ST_RDC);
  assign rd_addr = (state == ST_IDLE) ? prev : cur[AW-1:0];

  assign k = KW'(phase) + KW'(1);

  // Shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_DX: begin
        op_a = (NW+1)'(signed'({1'b0, rdata[2*CWD-1:CWD]}) - signed'({1'b0, ax}));
        op_b = signed'((RW+1)'(k));
      end
      ST_DY: begin
        op_a = (NW+1)'(signed'({1'b0, rdata[CWD-1:0]}) - signed'({1'b0, ay}));
        op_b = signed'((RW+1)'(k));
      end
      ST_QX, ST_QY: begin
        op_a = signed'({1'b0, num});
        op_b = signed'((RW+1)'(RECIP));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PRW'(op_a) * PRW'(op_b);
  end

  // num = a*S + (b-a)*k, always non-negative
  assign a_scaled = (state == ST_DY) ? NW'(ax) * NW'(STEPS_PER_SEGMENT)
                                     : NW'(ay) * NW'(STEPS_PER_SEGMENT);
  assign base     = signed'(PRW'(a_scaled));
  assign sum      = base + prod;
  assign qy       = prod[SH +: CWD];

  assign sx_full = {qx, 16'd0} - (CWD+16)'(qx);
  assign sy_full = {qy, 16'd0} - (CWD+16)'(qy);
  assign sx      = sx_full[xypip_pkg::SCALE_SHIFT +: xypip_pkg::SAMPLE_W];
  assign sy      = sy_full[xypip_pkg::SCALE_SHIFT +: xypip_pkg::SAMPLE_W];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (tick_accept) state_next = ST_RDC;
      ST_RDC:  state_next = ST_DX;
      ST_DX:   state_next = ST_DY;
      ST_DY:   state_next = ST_QX;
      ST_QX:   state_next = ST_QY;
      ST_QY:   state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_RDC) begin
      ax <= rdata[2*CWD-1:CWD];
      ay <= rdata[CWD-1:0];
    end
    if (state == ST_DY || state == ST_QX) begin
      num <= sum[NW-1:0];
    end
    if (state == ST_QY) begin
      qx <= prod[SH +: CWD];
    end
    if (state == ST_FIN) begin
      result.left_sample  <= signed'(sx - xypip_pkg::SAMPLE_MID);
      result.right_sample <= signed'(xypip_pkg::SAMPLE_MID - sy);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      num_points   <= xypip_pkg::CFG_W'(1);
      cur          <= '0;
      prev         <= '0;
      phase        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_FIN);
      if (num_points_we) begin
        num_points <= num_points_wdata;
      end
      // Wrap before the table read
      if (tick_accept) begin
        cur <= cur_wrapped;
      end
      if (state == ST_FIN) begin
        if (phase == '0) begin
          prev <= cur[AW-1:0];
          cur  <= cur + CW'(1);
        end
        if (32'(phase) + 32'd1 >= 32'(STEPS_PER_SEGMENT)) begin
          phase <= '0;
        end else begin
          phase <= phase + PW'(1);
        end
      end
    end
  end

  // Assertions
  a_strobe_after_fin: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_FIN))
    else $error("result strobe without a finished tick");

  a_tick_goes_busy: assert property (@(posedge clk) disable iff (rst)
    tick_accept |=> busy)
    else $error("tick accepted but sequencer did not start");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == xypip_pkg::KIND_LOAD) |=> !busy)
    else $error("load made the block busy");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    (busy && state != ST_FIN) |-> (32'(cur) < n32))
    else $error("current point out of range during a tick");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(phase) < 32'(STEPS_PER_SEGMENT))
    else $error("segment phase out of range");

endmodule
